// File: hw/rtl/jgns_pkg.sv
package jgns_pkg;

  // Default geometry, handed to the top level parameters.
  localparam int DEF_MAX_CELLS_PER_SIDE = 16;
  localparam int DEF_COORD_BITS = 12;

  // Fixed field widths.
  localparam int SITE_INDEX_W = 8;
  localparam int IMAGE_SIZE_W = 13;
  localparam int CELLS_W = 5;

  // Configuration port.
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] REG_IMAGE_WIDTH = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_CELLS_PER_SIDE = 2'd2;
  localparam logic [1:0] REG_TILE_ENABLE = 2'd3;

  localparam logic [IMAGE_SIZE_W-1:0] RST_IMAGE_WIDTH = 13'd256;
  localparam logic [IMAGE_SIZE_W-1:0] RST_IMAGE_HEIGHT = 13'd256;
  localparam logic [CELLS_W-1:0] RST_CELLS_PER_SIDE = 5'd4;
  localparam logic RST_TILE_ENABLE = 1'b0;

  // Item kinds on the input channel.
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Datapath operations issued by the controller, one per cycle.
  localparam int OP_W = 5;
  typedef logic [OP_W-1:0] dp_op_t;

  localparam dp_op_t OP_NOP = 5'd0;
  localparam dp_op_t OP_WRITE = 5'd1;
  localparam dp_op_t OP_LOAD = 5'd2;
  localparam dp_op_t OP_MUL_NPX = 5'd3;
  localparam dp_op_t OP_MUL_NPY = 5'd4;
  localparam dp_op_t OP_DIV_PW = 5'd5;
  localparam dp_op_t OP_DIV_PH = 5'd6;
  localparam dp_op_t OP_DIV_QN = 5'd7;
  localparam dp_op_t OP_SET_GX = 5'd8;
  localparam dp_op_t OP_SET_GY = 5'd9;
  localparam dp_op_t OP_SQ_W = 5'd10;
  localparam dp_op_t OP_SQ_H = 5'd11;
  localparam dp_op_t OP_INIT_SUM = 5'd12;
  localparam dp_op_t OP_BASE = 5'd13;
  localparam dp_op_t OP_DIV_PXW = 5'd14;
  localparam dp_op_t OP_SET_PMX = 5'd15;
  localparam dp_op_t OP_DIV_PYH = 5'd16;
  localparam dp_op_t OP_SET_PMY = 5'd17;
  localparam dp_op_t OP_SITE = 5'd18;
  localparam dp_op_t OP_DIV_SXW = 5'd19;
  localparam dp_op_t OP_SET_SMX = 5'd20;
  localparam dp_op_t OP_DIV_SYH = 5'd21;
  localparam dp_op_t OP_SET_SMY = 5'd22;
  localparam dp_op_t OP_DIST = 5'd23;
  localparam dp_op_t OP_SQ_DX = 5'd24;
  localparam dp_op_t OP_SQ_DY = 5'd25;
  localparam dp_op_t OP_CMP = 5'd26;
  localparam dp_op_t OP_EMIT = 5'd27;

  // Status returned by the datapath to the controller.
  typedef struct packed {
    logic div_done;
    logic base_last;
    logic scan_last;
    logic out_free;
    logic tile;
  } dp_status_t;

endpackage

// File: hw/rtl/jgns_in_if.sv
interface jgns_in_if #(
  parameter int COORD_BITS = 12
);
  logic valid;
  logic ready;
  logic mode;
  logic [7:0] site_index;
  logic [COORD_BITS-1:0] site_x;
  logic [COORD_BITS-1:0] site_y;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;

  modport source (
    output valid, mode, site_index, site_x, site_y, pixel_x, pixel_y,
    input ready
  );
  modport sink (
    input valid, mode, site_index, site_x, site_y, pixel_x, pixel_y,
    output ready
  );
endinterface

// File: hw/rtl/jgns_out_if.sv
interface jgns_out_if #(
  parameter int COORD_BITS = 12
);
  logic valid;
  logic ready;
  logic [COORD_BITS-1:0] nearest_x;
  logic [COORD_BITS-1:0] nearest_y;
  logic [2*COORD_BITS:0] x_dist_sq;
  logic [2*COORD_BITS:0] y_dist_sq;
  logic [2*COORD_BITS+1:0] dist_sq;

  modport source (
    output valid, nearest_x, nearest_y, x_dist_sq, y_dist_sq, dist_sq,
    input ready
  );
  modport sink (
    input valid, nearest_x, nearest_y, x_dist_sq, y_dist_sq, dist_sq,
    output ready
  );
endinterface

// File: hw/rtl/jgns_ram.sv
module jgns_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic clk,
  input  logic we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/jgns_div.sv
module jgns_div #(
  parameter int DVD_W = 17,
  parameter int DVS_W = 13
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder,
  output logic done
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] quo;
  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] dvs;
  logic [CNT_W-1:0] cnt;
  logic busy;
  logic [DVS_W:0] trial;
  logic ge;

  // One restoring step per cycle, most significant dividend bit first.
  always_comb begin
    trial = {rem, quo[DVD_W-1]};
    ge = trial >= {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[DVD_W-2:0], ge};
      rem <= ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt <= CNT_W'(DVD_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quotient = quo;
  assign remainder = rem;
  assign done = !busy;

endmodule

// File: hw/rtl/jgns_dp.sv
module jgns_dp #(
  parameter int MAX_CELLS_PER_SIDE = 16,
  parameter int COORD_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  input  jgns_pkg::dp_op_t op,
  output jgns_pkg::dp_status_t status,
  input  logic [jgns_pkg::SITE_INDEX_W-1:0] site_index,
  input  logic [COORD_BITS-1:0] site_x,
  input  logic [COORD_BITS-1:0] site_y,
  input  logic [COORD_BITS-1:0] pixel_x,
  input  logic [COORD_BITS-1:0] pixel_y,
  input  logic [COORD_BITS:0] width_eff,
  input  logic [COORD_BITS:0] height_eff,
  input  logic [$clog2(MAX_CELLS_PER_SIDE+1)-1:0] cells_eff,
  input  logic tile_en,
  jgns_out_if.source results
);

  import jgns_pkg::*;

  localparam int C = COORD_BITS;
  localparam int SZ_W = C + 1;
  localparam int NB = $clog2(MAX_CELLS_PER_SIDE + 1);
  localparam int DVS_W = (SZ_W > NB) ? SZ_W : NB;
  localparam int MUL_W = DVS_W;
  localparam int DVD_W = C + NB;
  localparam int DEPTH = MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CIDX_W = (MAX_CELLS_PER_SIDE > 1) ? $clog2(MAX_CELLS_PER_SIDE) : 1;
  localparam int AX_W = 2 * C + 1;
  localparam int SUM_W = 2 * C + 2;
  localparam logic [1:0] LAST_K = 2'd2;

  // Query context.
  logic [C-1:0] px, py;
  logic [SZ_W-1:0] w, h;
  logic [NB-1:0] n;
  logic tile;
  logic [DVD_W-1:0] prod;
  logic [CIDX_W-1:0] gx, gy;
  logic [ADDR_W-1:0] base [3];
  logic [C-1:0] pmx, pmy;

  // Current candidate.
  logic [C-1:0] sx, sy, smx, smy, dx, dy;
  logic [AX_W-1:0] sqx, sqy;

  // Best so far.
  logic [C-1:0] best_x, best_y;
  logic [AX_W-1:0] best_dx, best_dy;
  logic [SUM_W-1:0] best_sum;

  logic [1:0] ic, jc;
  logic out_valid;
  logic [C-1:0] out_x, out_y;
  logic [AX_W-1:0] out_dx, out_dy;
  logic [SUM_W-1:0] out_sum;

  logic [MUL_W-1:0] mul_a, mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic div_start;
  logic [DVD_W-1:0] div_dvd, div_q;
  logic [DVS_W-1:0] div_dvs, div_r;
  logic div_done;
  logic ram_we;
  logic [ADDR_W-1:0] ram_raddr;
  logic [2*C-1:0] ram_rdata;
  logic [CIDX_W-1:0] cx, cy;
  logic [SUM_W-1:0] cand_sum;

  // Neighbor cell index along one axis with wrap: k = 0 before, 1 same, 2 after.
  function automatic logic [CIDX_W-1:0] nbr(input logic [CIDX_W-1:0] g,
                                             input logic [NB-1:0] cnt,
                                             input logic [1:0] k);
    logic [CIDX_W-1:0] last;
    last = CIDX_W'(cnt - NB'(1));
    case (k)
      2'd0:    nbr = (g == '0) ? last : g - CIDX_W'(1);
      2'd1:    nbr = g;
      default: nbr = (g == last) ? '0 : g + CIDX_W'(1);
    endcase
  endfunction

  // Axis distance; with tiling, the shorter way around the period p.
  // pm and sm are pixel and site already reduced modulo p.
  function automatic logic [C-1:0] axis_dist(input logic [C-1:0] pix,
                                             input logic [C-1:0] site,
                                             input logic [C-1:0] pm,
                                             input logic [C-1:0] sm,
                                             input logic [SZ_W-1:0] p,
                                             input logic t);
    logic [C-1:0] lin;
    logic [SZ_W-1:0] a, b;
    lin = (pix >= site) ? pix - site : site - pix;
    a = (pm >= sm) ? SZ_W'(pm) - SZ_W'(sm) : SZ_W'(pm) + p - SZ_W'(sm);
    b = (a == '0) ? '0 : p - a;
    if (t) begin
      axis_dist = (a < b) ? C'(a) : C'(b);
    end else begin
      axis_dist = lin;
    end
  endfunction

  assign cx = nbr(gx, n, ic);
  assign cy = nbr(gy, n, jc);
  assign ram_raddr = ADDR_W'(cx) + base[jc];
  assign cand_sum = SUM_W'(sqx) + SUM_W'(sqy);
  assign ram_we = (op == OP_WRITE) && (32'(site_index) < DEPTH);

  // Shared multiplier.
  always_comb begin
    unique case (op)
      OP_MUL_NPX: begin mul_a = MUL_W'(n); mul_b = MUL_W'(px); end
      OP_MUL_NPY: begin mul_a = MUL_W'(n); mul_b = MUL_W'(py); end
      OP_SQ_W:    begin mul_a = MUL_W'(w); mul_b = MUL_W'(w); end
      OP_SQ_H:    begin mul_a = MUL_W'(h); mul_b = MUL_W'(h); end
      OP_BASE:    begin mul_a = MUL_W'(n); mul_b = MUL_W'(cy); end
      OP_SQ_DX:   begin mul_a = MUL_W'(dx); mul_b = MUL_W'(dx); end
      OP_SQ_DY:   begin mul_a = MUL_W'(dy); mul_b = MUL_W'(dy); end
      default:    begin mul_a = '0; mul_b = '0; end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Shared divider operands.
  assign div_start = op inside {OP_DIV_PW, OP_DIV_PH, OP_DIV_QN, OP_DIV_PXW,
                                OP_DIV_PYH, OP_DIV_SXW, OP_DIV_SYH};
  always_comb begin
    unique case (op)
      OP_DIV_PW:  begin div_dvd = prod; div_dvs = DVS_W'(w); end
      OP_DIV_PH:  begin div_dvd = prod; div_dvs = DVS_W'(h); end
      OP_DIV_QN:  begin div_dvd = div_q; div_dvs = DVS_W'(n); end
      OP_DIV_PXW: begin div_dvd = DVD_W'(px); div_dvs = DVS_W'(w); end
      OP_DIV_PYH: begin div_dvd = DVD_W'(py); div_dvs = DVS_W'(h); end
      OP_DIV_SXW: begin div_dvd = DVD_W'(sx); div_dvs = DVS_W'(w); end
      OP_DIV_SYH: begin div_dvd = DVD_W'(sy); div_dvs = DVS_W'(h); end
      default:    begin div_dvd = '0; div_dvs = '0; end
    endcase
  end

  jgns_div #(
    .DVD_W(DVD_W),
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .remainder(div_r),
    .done     (div_done)
  );

  jgns_ram #(
    .WIDTH(2 * C),
    .DEPTH(DEPTH)
  ) u_site_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ADDR_W'(site_index)),
    .wdata({site_y, site_x}),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    unique case (op)
      OP_LOAD: begin
        px <= pixel_x;
        py <= pixel_y;
        w <= width_eff;
        h <= height_eff;
        n <= cells_eff;
        tile <= tile_en;
      end
      OP_MUL_NPX, OP_MUL_NPY: prod <= DVD_W'(mul_p);
      OP_SET_GX: gx <= CIDX_W'(div_r);
      OP_SET_GY: gy <= CIDX_W'(div_r);
      OP_SQ_W: begin
        best_dx <= AX_W'(mul_p);
        best_x <= '0;
        best_y <= '0;
      end
      OP_SQ_H: best_dy <= AX_W'(mul_p);
      OP_INIT_SUM: best_sum <= SUM_W'(best_dx) + SUM_W'(best_dy);
      OP_BASE: base[jc] <= ADDR_W'(mul_p);
      OP_SET_PMX: pmx <= C'(div_r);
      OP_SET_PMY: pmy <= C'(div_r);
      OP_SITE: begin
        sx <= ram_rdata[C-1:0];
        sy <= ram_rdata[2*C-1:C];
      end
      OP_SET_SMX: smx <= C'(div_r);
      OP_SET_SMY: smy <= C'(div_r);
      OP_DIST: begin
        dx <= axis_dist(px, sx, pmx, smx, w, tile);
        dy <= axis_dist(py, sy, pmy, smy, h, tile);
      end
      OP_SQ_DX: sqx <= AX_W'(mul_p);
      OP_SQ_DY: sqy <= AX_W'(mul_p);
      OP_CMP: begin
        if (cand_sum < best_sum) begin
          best_x <= sx;
          best_y <= sy;
          best_dx <= sqx;
          best_dy <= sqy;
          best_sum <= cand_sum;
        end
      end
      OP_EMIT: begin
        out_x <= best_x;
        out_y <= best_y;
        out_dx <= best_dx;
        out_dy <= best_dy;
        out_sum <= best_sum;
      end
      default: begin
      end
    endcase
  end

  // Scan counters: jc walks the rows inside each column ic.
  always_ff @(posedge clk) begin
    if (rst) begin
      ic <= '0;
      jc <= '0;
    end else if (op == OP_LOAD) begin
      ic <= '0;
      jc <= '0;
    end else if (op == OP_BASE) begin
      jc <= (jc == LAST_K) ? 2'd0 : jc + 2'd1;
    end else if (op == OP_CMP) begin
      if (jc == LAST_K) begin
        jc <= '0;
        ic <= ic + 2'd1;
      end else begin
        jc <= jc + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op == OP_EMIT) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid = out_valid;
  assign results.nearest_x = out_x;
  assign results.nearest_y = out_y;
  assign results.x_dist_sq = out_dx;
  assign results.y_dist_sq = out_dy;
  assign results.dist_sq = out_sum;

  assign status.div_done = div_done;
  assign status.base_last = (jc == LAST_K);
  assign status.scan_last = (ic == LAST_K) && (jc == LAST_K);
  assign status.out_free = !out_valid || results.ready;
  assign status.tile = tile;

endmodule

// File: hw/rtl/jgns_ctrl.sv
module jgns_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic items_valid,
  input  logic items_mode,
  output logic items_ready,
  input  jgns_pkg::dp_status_t status,
  output jgns_pkg::dp_op_t op
);

  import jgns_pkg::*;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MNX  = 5'd1;
  localparam logic [4:0] S_DNX  = 5'd2;
  localparam logic [4:0] S_QX   = 5'd3;
  localparam logic [4:0] S_GX   = 5'd4;
  localparam logic [4:0] S_MNY  = 5'd5;
  localparam logic [4:0] S_DNY  = 5'd6;
  localparam logic [4:0] S_QY   = 5'd7;
  localparam logic [4:0] S_GY   = 5'd8;
  localparam logic [4:0] S_SQW  = 5'd9;
  localparam logic [4:0] S_SQH  = 5'd10;
  localparam logic [4:0] S_ISUM = 5'd11;
  localparam logic [4:0] S_BASE = 5'd12;
  localparam logic [4:0] S_DPX  = 5'd13;
  localparam logic [4:0] S_PMX  = 5'd14;
  localparam logic [4:0] S_DPY  = 5'd15;
  localparam logic [4:0] S_PMY  = 5'd16;
  localparam logic [4:0] S_RD   = 5'd17;
  localparam logic [4:0] S_SITE = 5'd18;
  localparam logic [4:0] S_DSX  = 5'd19;
  localparam logic [4:0] S_SMX  = 5'd20;
  localparam logic [4:0] S_DSY  = 5'd21;
  localparam logic [4:0] S_SMY  = 5'd22;
  localparam logic [4:0] S_DIST = 5'd23;
  localparam logic [4:0] S_SQX  = 5'd24;
  localparam logic [4:0] S_SQY  = 5'd25;
  localparam logic [4:0] S_CMP  = 5'd26;
  localparam logic [4:0] S_EMIT = 5'd27;

  logic [4:0] state, state_next;

  assign items_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    op = OP_NOP;
    unique case (state)
      S_IDLE: begin
        if (items_valid) begin
          if (items_mode == MODE_QUERY) begin
            op = OP_LOAD;
            state_next = S_MNX;
          end else begin
            op = OP_WRITE;
          end
        end
      end
      S_MNX: begin op = OP_MUL_NPX; state_next = S_DNX; end
      S_DNX: begin op = OP_DIV_PW; state_next = S_QX; end
      S_QX: begin
        if (status.div_done) begin op = OP_DIV_QN; state_next = S_GX; end
      end
      S_GX: begin
        if (status.div_done) begin op = OP_SET_GX; state_next = S_MNY; end
      end
      S_MNY: begin op = OP_MUL_NPY; state_next = S_DNY; end
      S_DNY: begin op = OP_DIV_PH; state_next = S_QY; end
      S_QY: begin
        if (status.div_done) begin op = OP_DIV_QN; state_next = S_GY; end
      end
      S_GY: begin
        if (status.div_done) begin op = OP_SET_GY; state_next = S_SQW; end
      end
      S_SQW: begin op = OP_SQ_W; state_next = S_SQH; end
      S_SQH: begin op = OP_SQ_H; state_next = S_ISUM; end
      S_ISUM: begin op = OP_INIT_SUM; state_next = S_BASE; end
      S_BASE: begin
        op = OP_BASE;
        if (status.base_last) begin
          state_next = status.tile ? S_DPX : S_RD;
        end
      end
      S_DPX: begin op = OP_DIV_PXW; state_next = S_PMX; end
      S_PMX: begin
        if (status.div_done) begin op = OP_SET_PMX; state_next = S_DPY; end
      end
      S_DPY: begin op = OP_DIV_PYH; state_next = S_PMY; end
      S_PMY: begin
        if (status.div_done) begin op = OP_SET_PMY; state_next = S_RD; end
      end
      S_RD: state_next = S_SITE;
      S_SITE: begin
        op = OP_SITE;
        state_next = status.tile ? S_DSX : S_DIST;
      end
      S_DSX: begin op = OP_DIV_SXW; state_next = S_SMX; end
      S_SMX: begin
        if (status.div_done) begin op = OP_SET_SMX; state_next = S_DSY; end
      end
      S_DSY: begin op = OP_DIV_SYH; state_next = S_SMY; end
      S_SMY: begin
        if (status.div_done) begin op = OP_SET_SMY; state_next = S_DIST; end
      end
      S_DIST: begin op = OP_DIST; state_next = S_SQX; end
      S_SQX: begin op = OP_SQ_DX; state_next = S_SQY; end
      S_SQY: begin op = OP_SQ_DY; state_next = S_CMP; end
      S_CMP: begin
        op = OP_CMP;
        state_next = status.scan_last ? S_EMIT : S_RD;
      end
      S_EMIT: begin
        if (status.out_free) begin op = OP_EMIT; state_next = S_IDLE; end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// File: hw/rtl/jittered_grid_nearest_site_top.sv
// Nearest feature point on a jittered grid (cellular noise, nearest site).
// The items channel carries two kinds of transfer. A write (mode 0) stores
// one site point in the table entry site_index and yields no result. A query
// (mode 1) gives a pixel; the block finds its grid cell,
// scans the 3x3 neighbor cells with wrap and sends one transfer on the
// results channel with the nearest site and its squared distances.
// The divider is bit-serial and DW = COORD_BITS + bits(MAX_CELLS_PER_SIDE)
// bits wide (DW = 17 by default). Two divisions per axis find the cell,
// and with tiling every candidate coordinate is reduced modulo the period
// by it too.
// One item is worked on at a time; items.ready is high only while idle.
// The result sits in an output register, so the next item is taken while a
// finished result still waits; a stalled receiver holds the block only when
// a second result is ready before the first has been taken.
// Reset (synchronous, active high) returns the configuration registers to
// their defaults and idles the controller; the site table is not cleared and
// must be written before a query reads an entry.
module jittered_grid_nearest_site_top #(
  parameter int MAX_CELLS_PER_SIDE = jgns_pkg::DEF_MAX_CELLS_PER_SIDE,
  parameter int COORD_BITS = jgns_pkg::DEF_COORD_BITS
) (
  input  logic clk,
  input  logic rst,
  jgns_in_if.sink items,
  jgns_out_if.source results,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [jgns_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [jgns_pkg::APB_DATA_W-1:0] pwdata,
  output logic [jgns_pkg::APB_DATA_W-1:0] prdata,
  output logic pready
);

  import jgns_pkg::*;

  localparam int SZ_W = COORD_BITS + 1;
  localparam int NB = $clog2(MAX_CELLS_PER_SIDE + 1);
  localparam int unsigned SIZE_LIMIT = 1 << COORD_BITS;

  // Configuration registers, written from the APB port; the user must write them only while idle (not enforced).
  logic [IMAGE_SIZE_W-1:0] image_width;
  logic [IMAGE_SIZE_W-1:0] image_height;
  logic [CELLS_W-1:0] cells_per_side;
  logic tile_enable;
  logic cfg_wr;
  logic [1:0] reg_idx;

  logic [SZ_W-1:0] width_eff, height_eff;
  logic [NB-1:0] cells_eff;
  dp_op_t op;
  dp_status_t status;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign reg_idx = paddr[APB_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
      cells_per_side <= RST_CELLS_PER_SIDE;
      tile_enable <= RST_TILE_ENABLE;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:    image_width <= pwdata[IMAGE_SIZE_W-1:0];
        REG_IMAGE_HEIGHT:   image_height <= pwdata[IMAGE_SIZE_W-1:0];
        REG_CELLS_PER_SIDE: cells_per_side <= pwdata[CELLS_W-1:0];
        REG_TILE_ENABLE:    tile_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:    prdata = APB_DATA_W'(image_width);
      REG_IMAGE_HEIGHT:   prdata = APB_DATA_W'(image_height);
      REG_CELLS_PER_SIDE: prdata = APB_DATA_W'(cells_per_side);
      REG_TILE_ENABLE:    prdata = APB_DATA_W'(tile_enable);
      default:            prdata = '0;
    endcase
  end

  // Sizes are clamped to 1 .. 2^COORD_BITS and the cell count to
  // 1 .. MAX_CELLS_PER_SIDE before a query uses them.
  always_comb begin
    if (image_width == '0) begin
      width_eff = SZ_W'(1);
    end else if (32'(image_width) > SIZE_LIMIT) begin
      width_eff = SZ_W'(SIZE_LIMIT);
    end else begin
      width_eff = SZ_W'(image_width);
    end

    if (image_height == '0) begin
      height_eff = SZ_W'(1);
    end else if (32'(image_height) > SIZE_LIMIT) begin
      height_eff = SZ_W'(SIZE_LIMIT);
    end else begin
      height_eff = SZ_W'(image_height);
    end

    if (cells_per_side == '0) begin
      cells_eff = NB'(1);
    end else if (32'(cells_per_side) > MAX_CELLS_PER_SIDE) begin
      cells_eff = NB'(MAX_CELLS_PER_SIDE);
    end else begin
      cells_eff = NB'(cells_per_side);
    end
  end

  jgns_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .items_valid(items.valid),
    .items_mode (items.mode),
    .items_ready(items.ready),
    .status     (status),
    .op         (op)
  );

  jgns_dp #(
    .MAX_CELLS_PER_SIDE(MAX_CELLS_PER_SIDE),
    .COORD_BITS        (COORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (op),
    .status    (status),
    .site_index(items.site_index),
    .site_x    (items.site_x),
    .site_y    (items.site_y),
    .pixel_x   (items.pixel_x),
    .pixel_y   (items.pixel_y),
    .width_eff (width_eff),
    .height_eff(height_eff),
    .cells_eff (cells_eff),
    .tile_en   (tile_enable),
    .results   (results)
  );

endmodule

// File: tb/jgns_checker.sv
`timescale 1ns / 100ps

module jgns_checker import jgns_pkg::*; #(
  parameter int MAX_CELLS = DEF_MAX_CELLS_PER_SIDE,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic clk,
  input  logic rst,
  jgns_in_if items,
  jgns_out_if results,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic pready,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output int mismatches,
  output int queries_open
);

  localparam int DEPTH = MAX_CELLS * MAX_CELLS;
  localparam int SIZE_CAP = 1 << COORD_BITS;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [2*COORD_BITS:0] dx;
    logic [2*COORD_BITS:0] dy;
    logic [2*COORD_BITS+1:0] sum;
  } nearest_t;

  nearest_t pending_nearest[$];
  logic [COORD_BITS-1:0] stored_x [DEPTH];
  logic [COORD_BITS-1:0] stored_y [DEPTH];
  logic [IMAGE_SIZE_W-1:0] width_cfg;
  logic [IMAGE_SIZE_W-1:0] height_cfg;
  logic [CELLS_W-1:0] cells_cfg;
  logic tile_cfg;
  int fail_count = 0;

  // Squared distance along one axis; with wrap the shorter way around the period.
  function automatic int unsigned axis_sq(int site, int pix, int period, bit wrap);
    int diff;
    int a;
    int b;
    int d;
    diff = pix - site;
    if (wrap) begin
      a = diff % period;
      b = (-diff) % period;
      if (a < 0) a += period;
      if (b < 0) b += period;
      d = (a < b) ? a : b;
    end else begin
      d = (diff < 0) ? -diff : diff;
    end
    return d * d;
  endfunction

  function automatic nearest_t find_nearest(int px, int py);
    int w;
    int h;
    int n;
    int gx;
    int gy;
    int cx;
    int cy;
    int slot;
    int unsigned dx;
    int unsigned dy;
    int unsigned total;
    int unsigned best_total;
    nearest_t best;
    w = (width_cfg == 0) ? 1 : (width_cfg > SIZE_CAP) ? SIZE_CAP : int'(width_cfg);
    h = (height_cfg == 0) ? 1 : (height_cfg > SIZE_CAP) ? SIZE_CAP : int'(height_cfg);
    n = (cells_cfg == 0) ? 1 : (cells_cfg > MAX_CELLS) ? MAX_CELLS : int'(cells_cfg);
    gx = ((n * px) / w) % n;
    gy = ((n * py) / h) % n;
    best = '0;
    best.dx = w * w;
    best.dy = h * h;
    best_total = w * w + h * h;
    // Column of cells outer, row inner; only a strictly smaller sum replaces the best.
    for (int i = 0; i < 3; i++) begin
      cx = (gx + n + i - 1) % n;
      for (int j = 0; j < 3; j++) begin
        cy = (gy + n + j - 1) % n;
        slot = (cx + n * cy) % DEPTH;
        dx = axis_sq(stored_x[slot], px, w, tile_cfg);
        dy = axis_sq(stored_y[slot], py, h, tile_cfg);
        total = dx + dy;
        if (total < best_total) begin
          best.x = stored_x[slot];
          best.y = stored_y[slot];
          best.dx = dx;
          best.dy = dy;
          best_total = total;
        end
      end
    end
    best.sum = best_total;
    return best;
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    nearest_t seen;
    nearest_t want;
    if (rst) begin
      width_cfg = RST_IMAGE_WIDTH;
      height_cfg = RST_IMAGE_HEIGHT;
      cells_cfg = RST_CELLS_PER_SIDE;
      tile_cfg = RST_TILE_ENABLE;
      pending_nearest.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_IMAGE_WIDTH: width_cfg = pwdata[IMAGE_SIZE_W-1:0];
          REG_IMAGE_HEIGHT: height_cfg = pwdata[IMAGE_SIZE_W-1:0];
          REG_CELLS_PER_SIDE: cells_cfg = pwdata[CELLS_W-1:0];
          REG_TILE_ENABLE: tile_cfg = pwdata[0];
          default: ;
        endcase
      end
      // Results first: a query taken at this edge cannot have produced this transfer.
      if (results.valid && results.ready) begin
        seen.x = results.nearest_x;
        seen.y = results.nearest_y;
        seen.dx = results.x_dist_sq;
        seen.dy = results.y_dist_sq;
        seen.sum = results.dist_sq;
        if (pending_nearest.size() == 0) begin
          note_failure($sformatf("unexpected result: x=%0d y=%0d dx2=%0d dy2=%0d d2=%0d",
                                 seen.x, seen.y, seen.dx, seen.dy, seen.sum));
        end else begin
          want = pending_nearest.pop_front();
          if (seen !== want) begin
            note_failure($sformatf({"nearest site mismatch at %0t: expected x=%0d y=%0d ",
                                    "dx2=%0d dy2=%0d d2=%0d, got x=%0d y=%0d dx2=%0d ",
                                    "dy2=%0d d2=%0d"}, $realtime,
                                   want.x, want.y, want.dx, want.dy, want.sum,
                                   seen.x, seen.y, seen.dx, seen.dy, seen.sum));
          end
        end
      end
      if (items.valid && items.ready) begin
        if (items.mode == MODE_WRITE) begin
          if (items.site_index < DEPTH) begin
            stored_x[items.site_index] = items.site_x;
            stored_y[items.site_index] = items.site_y;
          end
        end else begin
          pending_nearest.push_back(find_nearest(items.pixel_x, items.pixel_y));
        end
      end
    end
    mismatches <= fail_count;
    queries_open <= pending_nearest.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps

// Stimulus and verdict for the nearest-site block. The checker beside the
// block watches both channels and the register port, so this module only
// decides what to send, when each side idles, and when the run is over.
module tb;
  import jgns_pkg::*;

  localparam int COORD_BITS = DEF_COORD_BITS;
  localparam int MAX_CELLS = DEF_MAX_CELLS_PER_SIDE;
  localparam int TABLE_SLOTS = MAX_CELLS * MAX_CELLS;
  localparam int COORD_MAX = (1 << COORD_BITS) - 1;
  // Receiver hold-off used to back the block up until it refuses input.
  localparam int HOLD_CYCLES = 2000;
  // Hang limit; this is many times both a tiled query and a receiver hold-off.
  localparam int STALL_LIMIT = 20000;
  // A write has no result, so after the last result a write may still be in flight.
  localparam int WRITE_SETTLE = 16;
  // After the last expected result, listen long enough for a stray tiled query.
  localparam int END_DRAIN = 600;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  int mismatches;
  int queries_open;
  int idle_pct;
  int stall_pct;
  logic hold_req;
  bit site_written [TABLE_SLOTS];
  int quiet_cycles;

  jgns_in_if #(.COORD_BITS(COORD_BITS)) items_ch ();
  jgns_out_if #(.COORD_BITS(COORD_BITS)) results_ch ();

  jittered_grid_nearest_site_top #(
    .MAX_CELLS_PER_SIDE(MAX_CELLS),
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .items(items_ch),
    .results(results_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  jgns_checker #(
    .MAX_CELLS(MAX_CELLS),
    .COORD_BITS(COORD_BITS)
  ) checker_inst (
    .clk(clk),
    .rst(rst),
    .items(items_ch),
    .results(results_ch),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .pready(pready),
    .paddr(paddr),
    .pwdata(pwdata),
    .mismatches(mismatches),
    .queries_open(queries_open)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // A transfer on either channel counts as progress. A long run of cycles
  // without one means the block has hung, so the run ends as a failure.
  wire moved = (items_ch.valid && items_ch.ready) || (results_ch.valid && results_ch.ready);

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver. It stalls at the rate set for the phase. When the stimulus
  // toggles hold_req, it drops ready for a long, fixed stretch so that one
  // result sits in the output register, a second finishes behind it, and
  // the block stops taking items while the sender keeps offering them.
  initial begin
    logic hold_seen;
    hold_seen = 1'b0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        results_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      results_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Image size and cell count as the block uses them after
  // clamping; the stimulus needs them to aim pixels and writes.
  function automatic int usable_size(int v);
    return (v == 0) ? 1 : (v > COORD_MAX + 1) ? COORD_MAX + 1 : v;
  endfunction

  function automatic int usable_cells(int v);
    return (v == 0) ? 1 : (v > MAX_CELLS) ? MAX_CELLS : v;
  endfunction

  // Mostly inside the image, with the edges and the full field range mixed in.
  function automatic logic [COORD_BITS-1:0] pick_coord(int span);
    case ($urandom_range(19))
      0: return '0;
      1: return span - 1;
      2: return $urandom_range(COORD_MAX);
      default: return $urandom_range(span - 1);
    endcase
  endfunction

  // Offers one item, possibly after some idle cycles, and returns at the
  // edge where the transfer happened. Valid stays high on return so that a
  // back-to-back item does not drop and raise it within one step.
  task automatic push_item(logic mode, logic [SITE_INDEX_W-1:0] idx,
                           logic [COORD_BITS-1:0] sx, logic [COORD_BITS-1:0] sy,
                           logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    while ($urandom_range(99) < idle_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid <= 1'b1;
    items_ch.mode <= mode;
    items_ch.site_index <= idx;
    items_ch.site_x <= sx;
    items_ch.site_y <= sy;
    items_ch.pixel_x <= px;
    items_ch.pixel_y <= py;
    if (mode == MODE_WRITE) site_written[idx] = 1'b1;
    do @(posedge clk); while (!items_ch.ready);
  endtask

  // Lets every expected result drain, then waits out any trailing write.
  task automatic wait_idle(int settle);
    items_ch.valid <= 1'b0;
    do @(posedge clk); while (queries_open != 0);
    repeat (settle) @(posedge clk);
  endtask

  // Writes all four registers back to back. Each write is a setup phase and
  // an access phase; psel stays high between writes and drops after the last.
  task automatic set_geometry(int w, int h, int n, int tile);
    logic [APB_DATA_W-1:0] vals [4];
    logic [1:0] sel [4];
    vals = '{w, h, n, tile};
    sel = '{REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_CELLS_PER_SIDE, REG_TILE_ENABLE};
    for (int k = 0; k < 4; k++) begin
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {sel[k], 2'b00};
      pwdata <= vals[k];
      @(posedge clk);
      penable <= 1'b1;
      do @(posedge clk); while (!pready);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // One phase: wait for idle, program the geometry, make sure every table
  // entry the grid can reach has been written, then send random items.
  task automatic run_phase(int w, int h, int n, int tile, int idle, int stall,
                           int count, bit pressure);
    int we;
    int he;
    int ne;
    logic [SITE_INDEX_W-1:0] idx;
    wait_idle(WRITE_SETTLE);
    set_geometry(w, h, n, tile);
    idle_pct = idle;
    stall_pct <= stall;
    we = usable_size(w);
    he = usable_size(h);
    ne = usable_cells(n);
    for (int i = 0; i < ne * ne; i++) begin
      if (!site_written[i]) begin
        push_item(MODE_WRITE, i, pick_coord(we), pick_coord(he),
                  $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
      end
    end
    if (pressure) hold_req <= ~hold_req;
    repeat (count) begin
      if ($urandom_range(99) < 25) begin
        // Site moves. Most land inside the active grid; some anywhere in
        // the table. The pixel fields are don't-care and carry noise.
        idx = ($urandom_range(4) == 0) ? $urandom_range(TABLE_SLOTS - 1)
                                       : $urandom_range(ne * ne - 1);
        push_item(MODE_WRITE, idx, pick_coord(we), pick_coord(he),
                  $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
      end else begin
        push_item(MODE_QUERY, $urandom_range(TABLE_SLOTS - 1),
                  $urandom_range(COORD_MAX), $urandom_range(COORD_MAX),
                  pick_coord(we), pick_coord(he));
      end
    end
  endtask

  initial begin
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    items_ch.valid <= 1'b0;
    items_ch.mode <= MODE_WRITE;
    items_ch.site_index <= '0;
    items_ch.site_x <= '0;
    items_ch.site_y <= '0;
    items_ch.pixel_x <= '0;
    items_ch.pixel_y <= '0;
    hold_req <= 1'b0;
    stall_pct <= 0;
    idle_pct = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part under the reset geometry (256 x 256, 4 cells, no tiling).
    // Every site sits far outside the image, so the first queries see no
    // candidate beat the starting distance and return the origin.
    for (int i = 0; i < 16; i++) begin
      push_item(MODE_WRITE, i, COORD_MAX, COORD_MAX, '0, '0);
    end
    push_item(MODE_QUERY, '0, '0, '0, '0, '0);
    // A pixel far outside the image wraps to the last cell and hits a site.
    push_item(MODE_QUERY, '0, '0, '0, COORD_MAX, COORD_MAX);
    push_item(MODE_QUERY, '0, '0, '0, 100, 200);
    push_item(MODE_WRITE, 0, '0, '0, COORD_MAX, COORD_MAX);
    push_item(MODE_WRITE, 15, 255, 255, '0, '0);
    push_item(MODE_QUERY, '0, '0, '0, '0, '0);
    push_item(MODE_QUERY, '0, '0, '0, 255, 255);
    push_item(MODE_QUERY, '0, '0, '0, COORD_MAX, '0);
    push_item(MODE_QUERY, '0, '0, '0, 128, 128);

    // Random phases. Sender idle and receiver stall rates rotate through
    // none, sender only, receiver only and both. The geometry covers the
    // smallest and largest legal settings and out-of-range register values
    // (zero and oversized image sizes and cell counts) that the block clamps.
    run_phase(256, 256, 4, 0, 0, 0, 150, 1'b1);
    run_phase(640, 480, 8, 1, 46, 0, 150, 1'b0);
    run_phase(4096, 4096, 16, 0, 0, 46, 150, 1'b0);
    run_phase(1, 1, 1, 1, 33, 33, 80, 1'b0);
    run_phase(100, 37, 3, 1, 0, 0, 150, 1'b1);
    run_phase(0, 5000, 0, 0, 33, 33, 100, 1'b0);
    run_phase(8191, 3, 31, 1, 46, 0, 100, 1'b0);
    run_phase(4096, 4096, 16, 1, 0, 46, 150, 1'b0);
    run_phase(333, 777, 5, 0, 33, 33, 150, 1'b0);
    run_phase(50, 4096, 2, 1, 0, 0, 150, 1'b0);

    wait_idle(END_DRAIN);
    if (mismatches == 0 && queries_open == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
